### rtl/assert_macros.svh
// Assertion helpers used by the curve point generator RTL.
// Each macro expects the signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/chcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chcp_pkg
// Shared constants for the cubic Hermite curve point generator.
// ----------------------------------------------------------------------------
package chcp_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_COORD_BITS = 16;
  localparam int DEF_FRAC_BITS  = 16;

  // Width of the point count field.
  localparam int NUM_W = 7;

  // Coefficient slots per axis, in Horner order.
  localparam logic [1:0] COEF_A = 2'd0;
  localparam logic [1:0] COEF_B = 2'd1;
  localparam logic [1:0] COEF_C = 2'd2;
  localparam logic [1:0] COEF_D = 2'd3;

endpackage

### rtl/cubic_hermite_curve_points.sv
`timescale 1ns / 1ps
// A curve is taken while the block is idle, then a bit-serial divider forms the
// parameter step, then every point is formed one axis after the other (per axis:
// one load, three Horner steps of multiply low, multiply high and accumulate, two
// rounding steps). No new curve is taken until its last point goes to the output.
// The single shared multiplier sets the point rate. Reset is synchronous and
// active low; it clears control state only, the coefficient store is not cleared.
// ----------------------------------------------------------------------------
// cubic_hermite_curve_points
// Evaluates a cubic Hermite curve at evenly spaced parameter values and
// streams the rounded, saturated points out, one transfer per point.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cubic_hermite_curve_points #(
  parameter int MAX_POINTS = chcp_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = chcp_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = chcp_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_p0_x,
  input  logic signed [COORD_BITS-1:0]  in_p0_y,
  input  logic signed [COORD_BITS-1:0]  in_tan0_x,
  input  logic signed [COORD_BITS-1:0]  in_tan0_y,
  input  logic signed [COORD_BITS-1:0]  in_p1_x,
  input  logic signed [COORD_BITS-1:0]  in_p1_y,
  input  logic signed [COORD_BITS-1:0]  in_tan1_x,
  input  logic signed [COORD_BITS-1:0]  in_tan1_y,
  input  logic [chcp_pkg::NUM_W-1:0]    in_num_points,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  out_pt_x,
  output logic signed [COORD_BITS-1:0]  out_pt_y,
  output logic                          out_last
);

  localparam int NUM_W  = chcp_pkg::NUM_W;
  localparam int COEF_W = COORD_BITS + 4;
  localparam int HI_W   = COORD_BITS + 5;
  localparam int ACC_W  = HI_W + FRAC_BITS;
  localparam int MA_W   = (HI_W > FRAC_BITS + 1) ? HI_W : FRAC_BITS + 1;
  localparam int T_W    = FRAC_BITS + 1;
  localparam int TB_W   = FRAC_BITS + 2;
  localparam int PR_W   = MA_W + TB_W;
  localparam int IDX_W  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int DC_W   = $clog2(FRAC_BITS + 1);

  localparam logic [T_W-1:0]          T_ONE  = T_W'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [HI_W-1:0]         LIM    = HI_W'(1) << (COORD_BITS - 1);
  localparam logic [COORD_BITS-1:0]   C_MIN  = COORD_BITS'(1) << (COORD_BITS - 1);
  localparam logic [COORD_BITS-1:0]   C_MAX  = ~C_MIN;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_MLO,
    ST_MHI,
    ST_ACC,
    ST_RND1,
    ST_RND2
  } state_t;

  function automatic logic signed [COEF_W-1:0] herm_a(
    input logic signed [COEF_W-1:0] p0,
    input logic signed [COEF_W-1:0] s0,
    input logic signed [COEF_W-1:0] p1,
    input logic signed [COEF_W-1:0] s1
  );
    return (p0 <<< 1) + s0 - (p1 <<< 1) + s1;
  endfunction

  function automatic logic signed [COEF_W-1:0] herm_b(
    input logic signed [COEF_W-1:0] p0,
    input logic signed [COEF_W-1:0] s0,
    input logic signed [COEF_W-1:0] p1,
    input logic signed [COEF_W-1:0] s1
  );
    logic signed [COEF_W-1:0] dp;
    dp = p1 - p0;
    return (dp <<< 1) + dp - (s0 <<< 1) - s1;
  endfunction

  state_t                         state_r;
  logic                           axis_r;
  logic [1:0]                     hstep_r;
  logic signed [COEF_W-1:0]       coef_r [8];
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [ACC_W-1:0]        part_r;
  logic signed [PR_W-1:0]         prod_r;
  logic [T_W-1:0]                 t_r;
  logic [IDX_W-1:0]               tr_r;
  logic [T_W-1:0]                 q_r;
  logic [IDX_W-1:0]               rem_r;
  logic [IDX_W-1:0]               d_r;
  logic [IDX_W-1:0]               k_r;
  logic [DC_W-1:0]                div_cnt_r;
  logic [COORD_BITS-1:0]          ptx_r;
  logic                           out_valid_r;
  logic [COORD_BITS-1:0]          out_pt_x_r;
  logic [COORD_BITS-1:0]          out_pt_y_r;
  logic                           out_last_r;

  logic                           in_acc;
  logic [NUM_W-1:0]               n_cl;
  logic signed [HI_W-1:0]         acc_hi;
  logic [FRAC_BITS-1:0]           acc_lo;
  logic signed [MA_W-1:0]         mul_a;
  logic signed [TB_W-1:0]         mul_b;
  logic signed [PR_W-1:0]         prod;
  logic signed [COEF_W-1:0]       coef_sel;
  logic signed [ACC_W-1:0]        coef_q;
  logic signed [ACC_W-1:0]        lo_floor;
  logic [HI_W-1:0]                rnd_mag;
  logic [COORD_BITS-1:0]          sat_v;
  logic [IDX_W:0]                 rem_sh;
  logic                           div_ge;
  logic [IDX_W:0]                 tr_sum;
  logic                           tr_wrap;
  logic                           out_free;
  logic                           emit;
  logic                           is_last;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign n_cl      = (in_num_points > NUM_W'(MAX_POINTS)) ? NUM_W'(MAX_POINTS) : in_num_points;

  // Shared multiplier: fraction part of the accumulator first, integer part second.
  assign acc_hi = acc_r[ACC_W-1:FRAC_BITS];
  assign acc_lo = acc_r[FRAC_BITS-1:0];
  assign mul_b  = {1'b0, t_r};

  always_comb begin
    if (state_r == ST_MLO) begin
      mul_a = MA_W'(acc_lo);
    end else begin
      mul_a = MA_W'(acc_hi);
    end
  end

  assign prod     = mul_a * mul_b;
  assign coef_sel = coef_r[{axis_r, hstep_r}];
  assign coef_q   = ACC_W'(coef_sel) <<< FRAC_BITS;
  assign lo_floor = ACC_W'(prod_r >>> FRAC_BITS);

  // Rounding: part_r holds the magnitude plus one half, so the integer part
  // is the magnitude rounded half away from zero.
  assign rnd_mag = part_r[ACC_W-1:FRAC_BITS];

  always_comb begin
    if (acc_r[ACC_W-1]) begin
      sat_v = (rnd_mag > LIM) ? C_MIN : COORD_BITS'(HI_W'(0) - rnd_mag);
    end else begin
      sat_v = (rnd_mag > LIM - HI_W'(1)) ? C_MAX : COORD_BITS'(rnd_mag);
    end
  end

  // Restoring division of 2^FRAC_BITS by the point count minus one.
  assign rem_sh = {rem_r, (div_cnt_r == DC_W'(FRAC_BITS))};
  assign div_ge = (rem_sh >= {1'b0, d_r});

  // The parameter advances by quotient plus a carried remainder, so each t
  // equals floor(k * 2^FRAC_BITS / (n - 1)) exactly.
  assign tr_sum  = {1'b0, tr_r} + {1'b0, rem_r};
  assign tr_wrap = (tr_sum >= {1'b0, d_r});

  assign out_free = !out_valid_r || !out_stall;
  assign is_last  = (k_r == d_r);
  assign emit     = (state_r == ST_RND2) && axis_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        out_pt_x_r  <= ptx_r;
        out_pt_y_r  <= sat_v;
        out_last_r  <= is_last;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            coef_r[{1'b0, chcp_pkg::COEF_A}] <= herm_a(COEF_W'(in_p0_x), COEF_W'(in_tan0_x),
                                                       COEF_W'(in_p1_x), COEF_W'(in_tan1_x));
            coef_r[{1'b0, chcp_pkg::COEF_B}] <= herm_b(COEF_W'(in_p0_x), COEF_W'(in_tan0_x),
                                                       COEF_W'(in_p1_x), COEF_W'(in_tan1_x));
            coef_r[{1'b0, chcp_pkg::COEF_C}] <= COEF_W'(in_tan0_x);
            coef_r[{1'b0, chcp_pkg::COEF_D}] <= COEF_W'(in_p0_x);
            coef_r[{1'b1, chcp_pkg::COEF_A}] <= herm_a(COEF_W'(in_p0_y), COEF_W'(in_tan0_y),
                                                       COEF_W'(in_p1_y), COEF_W'(in_tan1_y));
            coef_r[{1'b1, chcp_pkg::COEF_B}] <= herm_b(COEF_W'(in_p0_y), COEF_W'(in_tan0_y),
                                                       COEF_W'(in_p1_y), COEF_W'(in_tan1_y));
            coef_r[{1'b1, chcp_pkg::COEF_C}] <= COEF_W'(in_tan0_y);
            coef_r[{1'b1, chcp_pkg::COEF_D}] <= COEF_W'(in_p0_y);
            d_r       <= IDX_W'(n_cl - NUM_W'(1));
            rem_r     <= '0;
            div_cnt_r <= DC_W'(FRAC_BITS);
            // A count below two produces no points.
            if (n_cl >= NUM_W'(2)) begin
              state_r <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          q_r       <= {q_r[T_W-2:0], div_ge};
          rem_r     <= div_ge ? IDX_W'(rem_sh - {1'b0, d_r}) : IDX_W'(rem_sh);
          div_cnt_r <= div_cnt_r - DC_W'(1);
          if (div_cnt_r == '0) begin
            t_r     <= '0;
            tr_r    <= '0;
            k_r     <= '0;
            axis_r  <= 1'b0;
            hstep_r <= chcp_pkg::COEF_A;
            state_r <= ST_LOAD;
          end
        end

        ST_LOAD: begin
          acc_r   <= coef_q;
          hstep_r <= chcp_pkg::COEF_B;
          state_r <= ST_MLO;
        end

        ST_MLO: begin
          prod_r  <= prod;
          state_r <= ST_MHI;
        end

        ST_MHI: begin
          part_r  <= lo_floor + coef_q;
          prod_r  <= prod;
          state_r <= ST_ACC;
        end

        ST_ACC: begin
          acc_r <= ACC_W'(prod_r) + part_r;
          if (hstep_r == chcp_pkg::COEF_D) begin
            hstep_r <= chcp_pkg::COEF_A;
            state_r <= ST_RND1;
          end else begin
            hstep_r <= hstep_r + 2'd1;
            state_r <= ST_MLO;
          end
        end

        ST_RND1: begin
          part_r  <= acc_r[ACC_W-1] ? (HALF - acc_r) : (acc_r + HALF);
          state_r <= ST_RND2;
        end

        ST_RND2: begin
          if (!axis_r) begin
            ptx_r   <= sat_v;
            axis_r  <= 1'b1;
            state_r <= ST_LOAD;
          end else if (out_free) begin
            axis_r <= 1'b0;
            if (is_last) begin
              state_r <= ST_IDLE;
            end else begin
              k_r     <= k_r + IDX_W'(1);
              t_r     <= t_r + q_r + T_W'(tr_wrap);
              tr_r    <= tr_wrap ? IDX_W'(tr_sum - {1'b0, d_r}) : IDX_W'(tr_sum);
              state_r <= ST_LOAD;
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_pt_x  = out_pt_x_r;
  assign out_pt_y  = out_pt_y_r;
  assign out_last  = out_last_r;

  logic pt_busy;
  assign pt_busy = (state_r != ST_IDLE) && (state_r != ST_DIV);

  `ASSERT_CLK(a_t_in_range, pt_busy |-> (t_r <= T_ONE), "curve parameter exceeds one")
  `ASSERT_CLK(a_rem_below_div, pt_busy |-> (tr_r < d_r), "parameter remainder not below divisor")
  `ASSERT_CLK(a_index_bound, pt_busy |-> (k_r <= d_r), "point index past the final point")
  `ASSERT_CLK(a_last_at_end, emit && is_last |-> (t_r == T_ONE),
              "final point not evaluated at t equal to one")
  `ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == ST_IDLE) && !out_valid,
                 "block not idle after reset")

endmodule

### sim/cubic_hermite_curve_points_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_hermite_curve_points_test
// Feeds curves into the Hermite point generator. A short directed table comes
// first, then random curves. Result points are compared with a Horner evaluation
// of the same curve in fixed point, or with given end points for some directed
// rows, while both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module cubic_hermite_curve_points_test;

  localparam int HALF_PERIOD   = 5;
  localparam int COORD_W       = chcp_pkg::DEF_COORD_BITS;
  localparam int FRAC_W        = chcp_pkg::DEF_FRAC_BITS;
  localparam int MAX_PTS       = chcp_pkg::DEF_MAX_POINTS;
  localparam int RANDOM_CURVES = 394;
  localparam int DRAIN_CYCLES  = 2000;
  localparam int HOLD_AT_POINT = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam longint COORD_LIM = longint'(1) <<< (COORD_W - 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [chcp_pkg::NUM_W-1:0] num_t;

  typedef struct packed {
    coord_t p0_x, p0_y, tan0_x, tan0_y, p1_x, p1_y, tan1_x, tan1_y;
    num_t   num_points;
  } curve_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } point_t;

  typedef enum {ROW_PREDICTED, ROW_SILENT, ROW_ENDPOINTS} row_check_t;

  typedef struct {
    row_check_t check;
    curve_t     curve;
    point_t     first_pt;
    point_t     last_pt;
  } stim_row_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  curve_t in_curve;
  logic   out_valid;
  logic   out_stall;
  coord_t out_pt_x;
  coord_t out_pt_y;
  logic   out_last;

  point_t    pending_points[$];
  stim_row_t directed_rows[$];
  int        points_seen = 0;
  int        fail_count = 0;

  cubic_hermite_curve_points dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_p0_x       (in_curve.p0_x),
    .in_p0_y       (in_curve.p0_y),
    .in_tan0_x     (in_curve.tan0_x),
    .in_tan0_y     (in_curve.tan0_y),
    .in_p1_x       (in_curve.p1_x),
    .in_p1_y       (in_curve.p1_y),
    .in_tan1_x     (in_curve.tan1_x),
    .in_tan1_y     (in_curve.tan1_y),
    .in_num_points (in_curve.num_points),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pt_x      (out_pt_x),
    .out_pt_y      (out_pt_y),
    .out_last      (out_last)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Hermite basis row for one polynomial coefficient of one axis.
  function automatic int hermite_coef(input logic [1:0] slot,
                                      input coord_t p0, s0, p1, s1);
    case (slot)
      chcp_pkg::COEF_A: return 2 * int'(p0) + int'(s0) - 2 * int'(p1) + int'(s1);
      chcp_pkg::COEF_B: return -3 * int'(p0) - 2 * int'(s0) + 3 * int'(p1) - int'(s1);
      chcp_pkg::COEF_C: return int'(s0);
      default: return int'(p0);
    endcase
  endfunction

  // Horner steps in signed Q.FRAC_W; each product is floored by the
  // arithmetic shift. The sum is then rounded half away from zero and clipped.
  function automatic coord_t horner_axis_point(input int ca, cb, cc, cd,
                                               input longint tq);
    longint acc;
    longint mag;
    longint rnd;
    acc = longint'(ca) <<< FRAC_W;
    acc = ((acc * tq) >>> FRAC_W) + (longint'(cb) <<< FRAC_W);
    acc = ((acc * tq) >>> FRAC_W) + (longint'(cc) <<< FRAC_W);
    acc = ((acc * tq) >>> FRAC_W) + (longint'(cd) <<< FRAC_W);
    mag = (acc < 0) ? -acc : acc;
    rnd = (mag + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    if (acc < 0) return (rnd > COORD_LIM) ? coord_t'(-COORD_LIM) : coord_t'(-rnd);
    return (rnd > COORD_LIM - 1) ? coord_t'(COORD_LIM - 1) : coord_t'(rnd);
  endfunction

  function automatic void predict_curve_points(input curve_t c);
    int     cx[4];
    int     cy[4];
    int     n;
    longint tq;
    point_t pt;
    for (int j = 0; j < 4; j++) begin
      cx[j] = hermite_coef(2'(j), c.p0_x, c.tan0_x, c.p1_x, c.tan1_x);
      cy[j] = hermite_coef(2'(j), c.p0_y, c.tan0_y, c.p1_y, c.tan1_y);
    end
    n = (int'(c.num_points) > MAX_PTS) ? MAX_PTS : int'(c.num_points);
    if (n < 2) return;
    // Parameter is indexed from k, so the last point lands on t = 1.0 exactly.
    for (int k = 0; k < n; k++) begin
      tq = (longint'(k) <<< FRAC_W) / longint'(n - 1);
      pt.x = horner_axis_point(cx[chcp_pkg::COEF_A], cx[chcp_pkg::COEF_B],
                               cx[chcp_pkg::COEF_C], cx[chcp_pkg::COEF_D], tq);
      pt.y = horner_axis_point(cy[chcp_pkg::COEF_A], cy[chcp_pkg::COEF_B],
                               cy[chcp_pkg::COEF_C], cy[chcp_pkg::COEF_D], tq);
      pt.last = (k == n - 1);
      pending_points.push_back(pt);
    end
  endfunction

  function automatic coord_t pick_coord();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4) return coord_t'($urandom);
    if (sel < 8) return coord_t'(int'($urandom_range(1000)) - 500);
    if (sel == 8) return $urandom_range(1) ? coord_t'(COORD_LIM - 1) : coord_t'(-COORD_LIM);
    return coord_t'(int'($urandom_range(16)) - 8);
  endfunction

  // Mostly short curves keep the run fast; a tenth ask for more than the
  // maximum so the count is clipped.
  function automatic num_t pick_count();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return num_t'($urandom_range(1));
    if (sel < 70) return num_t'($urandom_range(12, 2));
    if (sel < 90) return num_t'($urandom_range(MAX_PTS, 13));
    return num_t'($urandom_range(127, MAX_PTS + 1));
  endfunction

  function automatic curve_t random_curve();
    curve_t c;
    c.p0_x = pick_coord();
    c.p0_y = pick_coord();
    c.tan0_x = pick_coord();
    c.tan0_y = pick_coord();
    c.p1_x = pick_coord();
    c.p1_y = pick_coord();
    c.tan1_x = pick_coord();
    c.tan1_y = pick_coord();
    c.num_points = pick_count();
    return c;
  endfunction

  task automatic add_row(input row_check_t chk,
                         input int p0x, p0y, s0x, s0y, p1x, p1y, s1x, s1y, n,
                         input int fx, fy, lx, ly);
    stim_row_t row;
    row.check = chk;
    row.curve = '{coord_t'(p0x), coord_t'(p0y), coord_t'(s0x), coord_t'(s0y),
                  coord_t'(p1x), coord_t'(p1y), coord_t'(s1x), coord_t'(s1y), num_t'(n)};
    row.first_pt = '{coord_t'(fx), coord_t'(fy), 1'b0};
    row.last_pt = '{coord_t'(lx), coord_t'(ly), 1'b1};
    directed_rows.push_back(row);
  endtask

  task automatic offer_curve(input curve_t c);
    @(negedge clk);
    in_curve <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic sender_gap(input bit allow);
    while (allow && $urandom_range(99) < 24) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    curve_t c;
    in_valid = 1'b0;
    in_curve = '0;
    rst_n = 1'b0;

    // With two points the ends are P0 and P1 exactly, so those rows carry
    // their results; counts below two give nothing.
    add_row(ROW_SILENT, 0, 0, 0, 0, 0, 0, 0, 0, 0,   0, 0, 0, 0);
    add_row(ROW_SILENT, 1234, -5, 300, -700, -1000, 42, 9, -9, 1,   0, 0, 0, 0);
    add_row(ROW_ENDPOINTS, 0, 0, 0, 0, 0, 0, 0, 0, 2,   0, 0, 0, 0);
    add_row(ROW_ENDPOINTS, -32768, 32767, 32767, -32768, 32767, -32768, -32768, 32767, 2,
            -32768, 32767, 32767, -32768);
    add_row(ROW_ENDPOINTS, 32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767, 2,
            32767, 32767, -32768, -32768);
    add_row(ROW_ENDPOINTS, 32767, -32768, 32767, 32767, 32767, -32768, -32768, -32768, 2,
            32767, -32768, 32767, -32768);
    add_row(ROW_PREDICTED, -32768, 32767, 32767, -32768, 32767, -32768, -32768, 32767, 64,
            0, 0, 0, 0);
    // Straight lines x = t and y = -t: the midpoint is a rounding tie.
    add_row(ROW_PREDICTED, 0, 0, 1, -1, 1, -1, 1, -1, 3,   0, 0, 0, 0);
    add_row(ROW_PREDICTED, 0, 0, 1, -1, 1, -1, 1, -1, 5,   0, 0, 0, 0);
    // Bulges past both rails between equal end points.
    add_row(ROW_PREDICTED, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767, 9,
            0, 0, 0, 0);
    add_row(ROW_PREDICTED, 21845, -21846, -21846, 21845, 21845, -21846, -21846, 21845, 127,
            0, 0, 0, 0);
    add_row(ROW_PREDICTED, -12345, 2345, -300, 4000, 15000, -9000, 800, -60, 65,
            0, 0, 0, 0);
    add_row(ROW_PREDICTED, -1, 1, -1, 1, 1, -1, 1, -1, 100,   0, 0, 0, 0);
    add_row(ROW_PREDICTED, 0, 0, 32767, -32768, 0, 0, 32767, -32768, 64,   0, 0, 0, 0);
    add_row(ROW_PREDICTED, -1000, 500, 2000, -1000, 1000, -500, 2000, -1000, 31,
            0, 0, 0, 0);
    add_row(ROW_SILENT, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1,
            0, 0, 0, 0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_curve(directed_rows[i].curve);
      if (directed_rows[i].check == ROW_PREDICTED) begin
        predict_curve_points(directed_rows[i].curve);
      end else if (directed_rows[i].check == ROW_ENDPOINTS) begin
        pending_points.push_back(directed_rows[i].first_pt);
        pending_points.push_back(directed_rows[i].last_pt);
      end
      sender_gap(1'b1);
    end

    for (int idx = 0; idx < RANDOM_CURVES; idx++) begin
      c = random_curve();
      offer_curve(c);
      predict_curve_points(c);
      sender_gap(!(idx >= 180 && idx < 260));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stalls, one long hold-off that backs the block up into
  // its input, and a stretch of results taken without any stall.
  initial begin
    int  hold_left;
    bit  held;
    out_stall = 1'b0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && points_seen >= HOLD_AT_POINT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (points_seen >= 2000 && points_seen < 2600) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 24);
      end
    end
  end

  always @(posedge clk) begin : check_points
    point_t exp_pt;
    if (rst_n && out_valid && !out_stall) begin
      points_seen++;
      if (pending_points.size() == 0) begin
        $error("point with no curve pending: x=%0d y=%0d last=%0b",
               out_pt_x, out_pt_y, out_last);
        fail_count++;
      end else begin
        exp_pt = pending_points.pop_front();
        if (out_pt_x !== exp_pt.x) begin
          $error("pt_x: expected %0d, got %0d", exp_pt.x, out_pt_x);
          fail_count++;
        end
        if (out_pt_y !== exp_pt.y) begin
          $error("pt_y: expected %0d, got %0d", exp_pt.y, out_pt_y);
          fail_count++;
        end
        if (out_last !== exp_pt.last) begin
          $error("last: expected %0b, got %0b", exp_pt.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Far beyond the slowest correct run: every curve at 64 points with stalls.
  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
